// ===== design/swam_pkg.sv =====
// ----------------------------------------------------------------------------
// swam_pkg: shared types and constants
// state codes, event and compare codes and glyphs for the sliding window
// average / min / max block
// ----------------------------------------------------------------------------
package swam_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_COMPARE = 3'd1,
        EV_CLEAR   = 3'd2,
        EV_MIN     = 3'd3,
        EV_MAX     = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CMP_NONE  = 2'd0,
        CMP_BELOW = 2'd1,
        CMP_ABOVE = 2'd2,
        CMP_EQUAL = 2'd3
    } t_cmp;

    // active-low seven-segment glyphs
    localparam logic [6:0] GLYPH_L     = 7'h47;
    localparam logic [6:0] GLYPH_G     = 7'h02;
    localparam logic [6:0] GLYPH_E     = 7'h06;
    localparam logic [6:0] GLYPH_BLANK = 7'h7f;

endpackage

// ===== design/sliding_window_avg_min_max.sv =====
// ----------------------------------------------------------------------------
// sliding_window_avg_min_max: windowed average, min and max of switch samples
// keeps the last WINDOW_DEPTH changed samples and reports held statistics
// plus a display event for every trigger edge
// ----------------------------------------------------------------------------
// usage
//   input stream s_axis: one transaction per switch reading (sample in tdata,
//   trigger and mode flags in tuser). output stream m_axis: exactly one
//   transaction per input transaction, in order.
//   a reading that differs from the previous one shifts into a row of
//   WINDOW_DEPTH cells; partial min / max move one cell per cycle, and the
//   average is the running sum shifted down, rounded toward zero
//   (WINDOW_DEPTH is a power of two).
//   a changed sample stays in ST_CALC for the min / max walk through the row;
//   an unchanged sample goes straight from ST_IDLE to ST_FINISH.
//   one reading is in work at a time; the next one is taken in the cycle after the
//   result is loaded.
//   stall: a result waiting in the output register does not block taking the
//   next reading; that reading finishes and then waits until the register
//   frees up. s_axis_tready drops while a reading is in work.
//   reset (synchronous, active low): window, sum, previous sample/trigger
//   and held values cleared to zero, output stream empty.
// ----------------------------------------------------------------------------
module sliding_window_avg_min_max
    import swam_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // input stream
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata: sample, zero padded to bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    // tuser: trigger, mode
    input  logic [1:0]                                   s_axis_tuser,
    // output stream
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // tdata: average, window_min, window_max, compare_code, segment_pattern,
    // zero padded to bytes
    output logic [((3*SAMPLE_WIDTH+9+7)/8)*8-1:0]        m_axis_tdata,
    // tuser: event_res
    output logic [2:0]                                   m_axis_tuser
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int SUM_W   = SW + $clog2(WINDOW_DEPTH) + 1;
    localparam int CALC_N  = WINDOW_DEPTH;
    localparam int CNT_W   = $clog2(CALC_N + 1);
    localparam int OUT_W   = ((3*SAMPLE_WIDTH+9+7)/8)*8;
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CALC_N - 1);

    // ---------------------------------------------------------------- input
    logic signed [SW-1:0] w_in_sample;
    logic                 w_in_trig;
    logic                 w_in_mode;
    logic                 w_accept;
    logic                 w_changed;

    assign w_in_sample = s_axis_tdata[SW-1:0];
    assign w_in_trig   = s_axis_tuser[0];
    assign w_in_mode   = s_axis_tuser[1];
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- registers
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic signed [SW-1:0] r_prev_sample;
    logic                 r_prev_trig;
    logic signed [SW-1:0] r_sample;
    logic                 r_changed;
    logic                 r_falling;
    logic                 r_rising;
    logic                 r_mode;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SW-1:0] r_hold_avg;
    logic signed [SW-1:0] r_hold_min;
    logic signed [SW-1:0] r_hold_max;
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_avg;
    logic signed [SW-1:0] r_out_min;
    logic signed [SW-1:0] r_out_max;
    t_event               r_out_ev;
    t_cmp                 r_out_cmp;
    logic [6:0]           r_out_seg;

    assign w_changed   = (w_in_sample != r_prev_sample);

    // control from the sequencer
    logic     w_shift;
    logic     w_finish;

    // ---------------------------------------------------------------- window cells
    logic signed [SW-1:0] w_data [WINDOW_DEPTH];
    logic signed [SW-1:0] w_min  [WINDOW_DEPTH];
    logic signed [SW-1:0] w_max  [WINDOW_DEPTH];

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        logic signed [SW-1:0] w_next;
        logic signed [SW-1:0] w_cmin;
        logic signed [SW-1:0] w_cmax;

        // newest sample enters at the top, oldest entry sits in cell 0
        if (k == WINDOW_DEPTH - 1) begin : g_top
            assign w_next = w_in_sample;
        end else begin : g_mid
            assign w_next = w_data[k+1];
        end

        // cell 0 starts the min / max chain with its own entry
        if (k == 0) begin : g_first
            assign w_cmin = w_data[0];
            assign w_cmax = w_data[0];
        end else begin : g_rest
            assign w_cmin = w_min[k-1];
            assign w_cmax = w_max[k-1];
        end

        swam_cell #(
            .SAMPLE_WIDTH (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_data  (w_next),
            .i_min   (w_cmin),
            .i_max   (w_cmax),
            .o_data  (w_data[k]),
            .o_min   (w_min[k]),
            .o_max   (w_max[k])
        );
    end

    // ---------------------------------------------------------------- running sum
    logic signed [SUM_W-1:0] w_new_sum;
    logic signed [SW-1:0]    w_avg;

    assign w_new_sum = r_sum - SUM_W'(w_data[0]) + SUM_W'(w_in_sample);

    // truncation toward zero of the registered sum
    swam_div #(
        .DIVIDEND_W (SUM_W),
        .QUOTIENT_W (SW),
        .DIVISOR    (WINDOW_DEPTH)
    ) u_div (
        .i_dividend (r_sum),
        .o_quotient (w_avg)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_changed ? ST_CALC : ST_FINISH;
                end
            end
            ST_CALC: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready  = 1'b0;
        w_shift        = 1'b0;
        w_finish       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready  = 1'b1;
                w_shift        = w_accept && w_changed;
            end
            ST_CALC: begin
            end
            ST_FINISH: begin
                w_finish = !r_out_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CALC && r_cnt != CNT_LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // ---------------------------------------------------------------- state of the reading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_prev_trig   <= 1'b0;
            r_sum         <= '0;
            r_hold_avg    <= '0;
            r_hold_min    <= '0;
            r_hold_max    <= '0;
        end else begin
            if (w_accept) begin
                r_prev_sample <= w_in_sample;
                r_prev_trig   <= w_in_trig;
            end
            if (w_shift) begin
                r_sum <= w_new_sum;
            end
            if (w_finish && r_changed) begin
                r_hold_avg <= w_avg;
                r_hold_min <= w_min[WINDOW_DEPTH-1];
                r_hold_max <= w_max[WINDOW_DEPTH-1];
            end
        end
    end

    // captured reading, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample  <= w_in_sample;
            r_changed <= w_changed;
            r_falling <= r_prev_trig && !w_in_trig;
            r_rising  <= !r_prev_trig && w_in_trig;
            r_mode    <= w_in_mode;
        end
    end

    // ---------------------------------------------------------------- event
    logic signed [SW-1:0] w_res_avg;
    logic signed [SW-1:0] w_res_min;
    logic signed [SW-1:0] w_res_max;
    t_event               w_ev;
    t_cmp                 w_cmp;
    logic [6:0]           w_seg;

    // fresh statistics on a changed reading, held ones otherwise
    assign w_res_avg = r_changed ? w_avg : r_hold_avg;
    assign w_res_min = r_changed ? w_min[WINDOW_DEPTH-1] : r_hold_min;
    assign w_res_max = r_changed ? w_max[WINDOW_DEPTH-1] : r_hold_max;

    always_comb begin
        w_ev  = EV_NONE;
        w_cmp = CMP_NONE;
        w_seg = GLYPH_BLANK;
        if (r_mode) begin
            if (r_falling) begin
                w_ev = EV_COMPARE;
                if (w_res_avg < r_sample) begin
                    w_cmp = CMP_BELOW;
                    w_seg = GLYPH_L;
                end else if (w_res_avg > r_sample) begin
                    w_cmp = CMP_ABOVE;
                    w_seg = GLYPH_G;
                end else begin
                    w_cmp = CMP_EQUAL;
                    w_seg = GLYPH_E;
                end
            end else if (r_rising) begin
                w_ev = EV_CLEAR;
            end
        end else begin
            if (r_falling) begin
                w_ev = EV_MIN;
            end else if (r_rising) begin
                w_ev = EV_MAX;
            end
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_avg <= w_res_avg;
            r_out_min <= w_res_min;
            r_out_max <= w_res_max;
            r_out_ev  <= w_ev;
            r_out_cmp <= w_cmp;
            r_out_seg <= w_seg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_seg, r_out_cmp, r_out_max, r_out_min, r_out_avg});
    assign m_axis_tuser  = r_out_ev;

`ifndef NO_ASSERTIONS
    // one reading in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input taken while a reading is in work");

    // only a compare event carries a glyph
    a_glyph_only_on_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_ev != EV_COMPARE) |->
            (r_out_cmp == CMP_NONE && r_out_seg == GLYPH_BLANK))
        else $error("glyph shown without compare event");

    // window minimum never above window maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_min <= r_out_max))
        else $error("window min above window max");

    // step counter idles outside the calculation
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CALC) |-> (r_cnt == '0))
        else $error("step counter running outside calculation");
`endif

endmodule

// ===== design/swam_cell.sv =====
// ----------------------------------------------------------------------------
// swam_cell: one window entry
// holds one sample, shifts toward the oldest end and folds its entry into
// the running min / max handed along from the neighbor
// ----------------------------------------------------------------------------
module swam_cell
    import swam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic signed [SAMPLE_WIDTH-1:0] i_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_min,
    input  logic signed [SAMPLE_WIDTH-1:0] i_max,
    output logic signed [SAMPLE_WIDTH-1:0] o_data,
    output logic signed [SAMPLE_WIDTH-1:0] o_min,
    output logic signed [SAMPLE_WIDTH-1:0] o_max
);

    logic signed [SAMPLE_WIDTH-1:0] r_data;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    // partial results move one cell per cycle
    always_ff @(posedge i_clk) begin
        r_min <= (r_data < i_min) ? r_data : i_min;
        r_max <= (r_data > i_max) ? r_data : i_max;
    end

    assign o_data = r_data;
    assign o_min  = r_min;
    assign o_max  = r_max;

endmodule

// ===== design/swam_div.sv =====
// ----------------------------------------------------------------------------
// swam_div: signed divide by a power-of-two constant
// arithmetic shift with a bias on negative dividends, so the quotient is
// truncated toward zero
// ----------------------------------------------------------------------------
module swam_div #(
    parameter int DIVIDEND_W = 21,
    parameter int QUOTIENT_W = 16,
    parameter int DIVISOR    = 16
) (
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    output logic signed [QUOTIENT_W-1:0] o_quotient
);

    localparam int SHIFT = $clog2(DIVISOR);
    localparam logic signed [DIVIDEND_W-1:0] BIAS = DIVIDEND_W'(DIVISOR - 1);

    logic signed [DIVIDEND_W-1:0] w_biased;
    logic signed [DIVIDEND_W-1:0] w_shifted;

    // negative dividends are lifted by divisor - 1 so the shift rounds up
    assign w_biased   = i_dividend[DIVIDEND_W-1] ? (i_dividend + BIAS) : i_dividend;
    assign w_shifted  = w_biased >>> SHIFT;
    assign o_quotient = w_shifted[QUOTIENT_W-1:0];

endmodule
